[src/sorted_table_binary_search_macros.svh]
// Assertion macros used by the sorted table search RTL.
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/stbs_pkg.sv]
// Package with the command codes and fixed field widths of the sorted table search.
`default_nettype none

package stbs_pkg;

    localparam int CMD_WIDTH = 2;
    localparam int POS_WIDTH = 10;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_APPEND = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

endpackage

`default_nettype wire

[src/sorted_table_binary_search.sv]
// Top level of the sorted table binary search: table memory, entry count and search engine.
//
//  Channel   | Ports                  | Handshake
//  ----------+------------------------+------------------------------------------
//  command   | cmd, value             | taken at a clock edge with start=1, busy=0
//  result    | found, position        | done high for exactly one cycle
//
// An append or a clear leaves the block idle; start may be raised again in the very next cycle.
// A search issues its first probe read when it is taken, then compares one probe at a time,
// at most floor(log2(entry count)) + 1 probes (11 at a depth of 1024); done rises in the cycle after
// the last probe. The single read port of the table memory sets the rate: one probe per cycle.
// A search on an empty table answers in the cycle after it is taken.
// Reset clears the entry count and the control state; the table contents are not cleared.
// The receiver cannot stall; busy is high only while a search is probing.
`default_nettype none

module sorted_table_binary_search #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [stbs_pkg::CMD_WIDTH-1:0] cmd,
    input  wire logic signed [DATA_WIDTH-1:0]  value,
    output logic                               done,
    output logic                               found,
    output logic [stbs_pkg::POS_WIDTH-1:0]     position
);

    // AW indexes the table; CW holds a count or range bound up to DEPTH itself.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_PROBE
    } state_t;

    // The table memory. Only entries below the entry count are ever compared, and those have
    // all been written by appends, so no clearing pass is needed.
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]         rd_addr;

    state_t                       state_reg;
    logic [CW-1:0]                count_reg;
    // The live search range is [lo_reg, end_reg); mid_reg is the entry whose word sits
    // in rd_data_reg during a probe cycle.
    logic [CW-1:0]                lo_reg;
    logic [CW-1:0]                end_reg;
    logic [AW-1:0]                mid_reg;
    logic signed [DATA_WIDTH-1:0] target_reg;
    logic                         done_reg;
    logic                         found_reg;
    logic [stbs_pkg::POS_WIDTH-1:0] position_reg;

    logic          accept;
    logic          table_full;
    logic [AW-1:0] first_mid;
    logic          hit;
    logic          go_up;
    logic [CW-1:0] lo_up;
    logic [CW:0]   sum_up;
    logic [CW:0]   sum_dn;
    logic [AW-1:0] mid_up;
    logic [AW-1:0] mid_dn;
    logic          more_up;
    logic          more_dn;
    logic [CW-1:0] mid_wide;
    logic [CW:0]   count_less_one;

    assign accept     = start && (state_reg == ST_IDLE);
    assign table_full = (count_reg == CW'(DEPTH));

    // The first probe sits at floor((count - 1) / 2).
    assign count_less_one = {1'b0, count_reg} - (CW + 1)'(1);
    assign first_mid      = count_less_one[AW:1];

    // Both possible next ranges and their midpoints are formed beside the compare, so the
    // compare only selects one of them and the next probe can be issued in the same cycle.
    assign mid_wide = CW'(mid_reg);
    assign hit      = (rd_data_reg == target_reg);
    assign go_up    = (target_reg > $signed(rd_data_reg));
    assign lo_up    = mid_wide + CW'(1);
    assign sum_up   = {1'b0, lo_up} + {1'b0, end_reg} - (CW + 1)'(1);
    assign sum_dn   = {1'b0, lo_reg} + {1'b0, mid_wide} - (CW + 1)'(1);
    assign mid_up   = sum_up[AW:1];
    assign mid_dn   = sum_dn[AW:1];
    assign more_up  = (lo_up < end_reg);
    assign more_dn  = (lo_reg < mid_wide);

    always_comb
    begin
        if (state_reg == ST_PROBE)
        begin
            rd_addr = go_up ? mid_up : mid_dn;
        end
        else
        begin
            rd_addr = first_mid;
        end
    end

    // Table memory: one write port for appends, one registered read port for probes.
    always_ff @(posedge clk)
    begin
        if (accept && (stbs_pkg::cmd_t'(cmd) == stbs_pkg::CMD_APPEND) && !table_full)
        begin
            mem[count_reg[AW-1:0]] <= value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Control state and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
            position_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        found_reg    <= 1'b0;
                        position_reg <= '0;
                        unique case (stbs_pkg::cmd_t'(cmd))
                            stbs_pkg::CMD_APPEND:
                            begin
                                if (!table_full)
                                begin
                                    count_reg <= count_reg + CW'(1);
                                end
                            end
                            stbs_pkg::CMD_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            stbs_pkg::CMD_SEARCH:
                            begin
                                if (count_reg == '0)
                                begin
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= ST_PROBE;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_PROBE:
                begin
                    if (hit)
                    begin
                        found_reg    <= 1'b1;
                        position_reg <= stbs_pkg::POS_WIDTH'(mid_reg);
                    end
                    if (hit || (go_up ? !more_up : !more_dn))
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Search datapath: range bounds, probe index and target.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            target_reg <= value;
            lo_reg     <= '0;
            end_reg    <= count_reg;
            mid_reg    <= first_mid;
        end
        else if ((state_reg == ST_PROBE) && !hit)
        begin
            if (go_up)
            begin
                lo_reg  <= lo_up;
                mid_reg <= mid_up;
            end
            else
            begin
                end_reg <= mid_wide;
                mid_reg <= mid_dn;
            end
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign found    = found_reg;
    assign position = position_reg;

`include "sorted_table_binary_search_macros.svh"

    `STBS_ASSERT_NEXT(a_empty_search,
        accept && (cmd == stbs_pkg::CMD_SEARCH) && (count_reg == '0),
        done && !found, "Search on an empty table must answer not found at once.")
    `STBS_ASSERT_NEXT(a_no_result_other,
        accept && (cmd != stbs_pkg::CMD_SEARCH),
        !done, "Only a search may produce a result.")
    `STBS_ASSERT_NOW(a_miss_position,
        done && !found,
        position == '0, "A miss must report position zero.")
    `STBS_ASSERT_NOW(a_range_valid,
        state_reg == ST_PROBE,
        (lo_reg < end_reg) && (end_reg <= count_reg), "Probe range must be nonempty and inside the table.")
    `STBS_ASSERT_NOW(a_mid_in_range,
        state_reg == ST_PROBE,
        (mid_wide >= lo_reg) && (mid_wide < end_reg), "Probe index must lie within the live range.")

endmodule

`default_nettype wire

[tb/tb_sorted_table_binary_search.sv]
// Self-checking testbench for the sorted table binary search block.
`timescale 1ns / 100ps

module tb_sorted_table_binary_search;

    localparam int TABLE_DEPTH  = 1024;
    localparam int WORD_WIDTH   = 32;
    localparam int WORD_MIN     = int'(32'h8000_0000);
    localparam int WORD_MAX     = int'(32'h7fff_ffff);
    // A full-depth search makes one probe per cycle for at most eleven probes,
    // so this drain after the last answer is ample.
    localparam int DRAIN_CYCLES = 32;

    // One search answer: what the block should put on found and position.
    typedef struct packed {
        logic                           found;
        logic [stbs_pkg::POS_WIDTH-1:0] position;
    } search_answer_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic [stbs_pkg::CMD_WIDTH-1:0] cmd;
    logic signed [WORD_WIDTH-1:0]   value;
    logic                           done;
    logic                           found;
    logic [stbs_pkg::POS_WIDTH-1:0] position;

    // Mirror of the block's table and entry count, updated at each accepted
    // transaction. Entries at or above the count are stale and never consulted.
    int             table_words [TABLE_DEPTH];
    int             table_count;
    search_answer_t pending_answers [$];
    int             error_count;
    // Percentage chance that the sender pauses before a transaction.
    int             idle_pct;

    sorted_table_binary_search #(
        .DEPTH      (TABLE_DEPTH),
        .DATA_WIDTH (WORD_WIDTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .value    (value),
        .done     (done),
        .found    (found),
        .position (position)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Walk the same midpoint probes the block makes over [0, count-1] and
    // report the first probe that hits. On unsorted contents this still gives
    // exactly what those probes find, which is what the block must return.
    function automatic search_answer_t predict_search(input int target);
        search_answer_t answer;
        int             lo;
        int             hi;
        int             mid;
        answer = '0;
        lo = 0;
        hi = table_count - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (table_words[mid] == target)
            begin
                answer.found    = 1'b1;
                answer.position = mid[stbs_pkg::POS_WIDTH-1:0];
                return answer;
            end
            if (target > table_words[mid])
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return answer;
    endfunction

    // Apply one accepted transaction to the mirror. Appends to a full table
    // are dropped, a clear only resets the count, and the unused code does
    // nothing at all.
    function automatic void track_command(input stbs_pkg::cmd_t code, input int word);
        case (code)
            stbs_pkg::CMD_APPEND:
            begin
                if (table_count < TABLE_DEPTH)
                begin
                    table_words[table_count] = word;
                    table_count++;
                end
            end
            stbs_pkg::CMD_SEARCH: pending_answers = {pending_answers, predict_search(word)};
            stbs_pkg::CMD_CLEAR:  table_count = 0;
            default:    ;
        endcase
    endfunction

    // Everything here samples at the rising edge, before any of this edge's
    // nonblocking updates land, so the order of processes does not matter.
    // An answer strobed at the same edge that a new command is taken belongs
    // to the earlier search, so results are checked before the new
    // transaction is folded into the mirror.
    always @(posedge clk)
    begin : result_monitor
        search_answer_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_answers.size() == 0)
                begin
                    $error("search answer found=%0b position=%0d with no search pending",
                           found, position);
                    error_count++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0b, got %0b", want.found, found);
                        error_count++;
                    end
                    if (position !== want.position)
                    begin
                        $error("position: expected %0d, got %0d", want.position, position);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
                track_command(stbs_pkg::cmd_t'(cmd), value);
        end
    end

    // Present one transaction and return at the edge that takes it. start is
    // left high so back-to-back transactions need no extra cycle; it is only
    // lowered for an idle burst, which always waits on the clock before start rises
    // again, so the strobe never gets two assignments in one time step.
    task automatic send_command(input stbs_pkg::cmd_t code, input int word);
        if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= code;
        value <= word;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Table contents come in flavors: full-range words, a narrow band that
    // breeds duplicates, words at the ends of the signed range and around zero, and a middle band.
    function automatic int random_word(input int flavor);
        int corner;
        case (flavor)
            0: return $urandom;
            1: return $urandom_range(0, 16) - 8;
            2:
            begin
                corner = $urandom_range(0, 6);
                case (corner)
                    0: return WORD_MIN;
                    1: return WORD_MIN + 1;
                    2: return -1;
                    3: return 0;
                    4: return 1;
                    5: return WORD_MAX - 1;
                    default: return WORD_MAX;
                endcase
            end
            default: return $urandom_range(0, 2000) - 1000;
        endcase
    endfunction

    // Searches on an empty table, a clear with nothing loaded, and the
    // unused command code.
    task automatic test_empty_table();
        idle_pct = 30;
        send_command(stbs_pkg::CMD_SEARCH, 0);
        send_command(stbs_pkg::CMD_CLEAR, WORD_MAX);
        send_command(stbs_pkg::CMD_NOP, WORD_MIN);
        send_command(stbs_pkg::CMD_SEARCH, WORD_MAX);
    endtask

    // A five-entry table spanning the whole signed range, with hits at the
    // ends and in the middle and a miss that falls between two entries.
    task automatic test_field_extremes();
        idle_pct = 30;
        send_command(stbs_pkg::CMD_APPEND, WORD_MIN);
        send_command(stbs_pkg::CMD_APPEND, -1);
        send_command(stbs_pkg::CMD_APPEND, 0);
        send_command(stbs_pkg::CMD_APPEND, 1);
        send_command(stbs_pkg::CMD_APPEND, WORD_MAX);
        send_command(stbs_pkg::CMD_SEARCH, WORD_MIN);
        send_command(stbs_pkg::CMD_SEARCH, WORD_MAX);
        send_command(stbs_pkg::CMD_SEARCH, 0);
        send_command(stbs_pkg::CMD_SEARCH, -1);
        send_command(stbs_pkg::CMD_SEARCH, -2);
        send_command(stbs_pkg::CMD_NOP, 1);
        send_command(stbs_pkg::CMD_SEARCH, 1);
    endtask

    // Out-of-order contents: the block must follow its probes blindly; here both
    // searches still reach the words they look for.
    task automatic test_unsorted_table();
        idle_pct = 30;
        send_command(stbs_pkg::CMD_CLEAR, 0);
        send_command(stbs_pkg::CMD_APPEND, 30);
        send_command(stbs_pkg::CMD_APPEND, 10);
        send_command(stbs_pkg::CMD_APPEND, 20);
        send_command(stbs_pkg::CMD_SEARCH, 10);
        send_command(stbs_pkg::CMD_SEARCH, 20);
    endtask

    // Random load-then-search rounds. Most rounds clear, load a sorted run of
    // words and search for words that are there, neighbors of them, or
    // anything at all; a few keep the old table or load unsorted words.
    task automatic run_search_rounds(input int item_goal, input bit with_idle);
        int loaded [$];
        int fresh [$];
        int issued;
        int n_words;
        int n_searches;
        int flavor;
        int pick;
        int target;
        issued = 0;
        while (issued < item_goal)
        begin
            if (!with_idle)
                idle_pct = 0;
            else
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 25;
                    default: idle_pct = 60;
                endcase
            if (loaded.size() > 900 || $urandom_range(0, 3) != 0)
            begin
                send_command(stbs_pkg::CMD_CLEAR, $urandom);
                loaded.delete();
                issued++;
            end
            n_words = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 200)
                                                    : $urandom_range(0, 24);
            flavor = $urandom_range(0, 3);
            fresh.delete();
            repeat (n_words)
                fresh = {fresh, random_word(flavor)};
            if ($urandom_range(0, 7) != 0)
                fresh.sort();
            foreach (fresh[w])
            begin
                send_command(stbs_pkg::CMD_APPEND, fresh[w]);
                loaded = {loaded, fresh[w]};
                issued++;
            end
            n_searches = $urandom_range(1, 8);
            repeat (n_searches)
            begin
                pick = $urandom_range(0, 99);
                if (loaded.size() > 0 && pick < 60)
                    target = loaded[$urandom_range(0, loaded.size() - 1)];
                else if (loaded.size() > 0 && pick < 85)
                    target = loaded[$urandom_range(0, loaded.size() - 1)]
                             + ($urandom_range(0, 1) ? 1 : -1);
                else
                    target = random_word(flavor);
                // The unused code is thrown in now and then as noise.
                if ($urandom_range(0, 9) == 0)
                    send_command(stbs_pkg::CMD_NOP, $urandom);
                send_command(stbs_pkg::CMD_SEARCH, target);
                issued++;
            end
        end
    endtask

    // Fill the table to its depth with ascending words from the most negative
    // to the most positive, try a few appends that must be dropped, then
    // search deep into the full index range.
    task automatic test_full_table();
        int     words [$];
        int     dropped [$];
        longint acc;
        int     n;
        idle_pct = 20;
        send_command(stbs_pkg::CMD_CLEAR, 0);
        words = {words, WORD_MIN};
        acc = longint'(WORD_MIN) + 1;
        for (n = 1; n < TABLE_DEPTH - 1; n++)
        begin
            acc += $urandom_range(0, 4_000_000);
            if (acc > longint'(WORD_MAX) - 1)
                acc = longint'(WORD_MAX) - 1;
            words = {words, int'(acc)};
        end
        words = {words, WORD_MAX};
        foreach (words[w])
            send_command(stbs_pkg::CMD_APPEND, words[w]);
        repeat (3)
        begin
            dropped = {dropped, int'($urandom)};
            send_command(stbs_pkg::CMD_APPEND, dropped[dropped.size() - 1]);
        end
        send_command(stbs_pkg::CMD_SEARCH, words[0]);
        send_command(stbs_pkg::CMD_SEARCH, words[TABLE_DEPTH - 1]);
        send_command(stbs_pkg::CMD_SEARCH, words[TABLE_DEPTH / 2 - 1]);
        foreach (dropped[d])
            send_command(stbs_pkg::CMD_SEARCH, dropped[d]);
        repeat (24)
        begin
            if ($urandom_range(0, 3) != 0)
                send_command(stbs_pkg::CMD_SEARCH, words[$urandom_range(0, TABLE_DEPTH - 1)]);
            else
                send_command(stbs_pkg::CMD_SEARCH, $urandom);
        end
    endtask

    // The tail of the run streams short rounds with start held high, so each
    // transaction is presented as soon as the previous one is taken; it waits only while busy is high.
    task automatic test_back_to_back();
        run_search_rounds(30, 1'b0);
    endtask

    initial
    begin : stimulus
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = stbs_pkg::CMD_NOP;
        value       = '0;
        table_count = 0;
        error_count = 0;
        idle_pct    = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_field_extremes();
        test_unsorted_table();
        run_search_rounds(60, 1'b1);
        test_full_table();
        test_back_to_back();

        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // A correct run takes well under a millisecond even with every idle
    // burst at its longest; five milliseconds means the block has hung.
    initial
    begin : watchdog
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
